// ===== design/lbk_pkg.sv =====
// lbk_pkg: shared types and constants for the five-channel led blinker
// no dependencies

package lbk_pkg;

  localparam int ACTION_W  = 3;
  localparam int CHANNEL_W = 3;
  localparam int PERIOD_W  = 31;
  localparam int NOW_W     = 32;
  localparam int OUT_W     = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 3'd0,
    ACT_ON    = 3'd1,
    ACT_OFF   = 3'd2,
    ACT_BLINK = 3'd3,
    ACT_STOP  = 3'd4
  } action_t;

  // one input item as it sits in the input register
  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHANNEL_W-1:0] channel;
    logic [PERIOD_W-1:0]  interval_ms;
    logic [NOW_W-1:0]     now_ms;
  } item_t;

  // per-channel command strobes; all but tick are qualified by channel select
  typedef struct packed {
    logic tick;
    logic set_on;
    logic set_off;
    logic blink;
    logic stop;
  } chan_cmd_t;

endpackage

// ===== design/lbk_in_stage.sv =====
// lbk_in_stage: input register of the blinker pipeline
// depends on lbk_pkg

module lbk_in_stage
  import lbk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== design/lbk_chan.sv =====
// lbk_chan: state and update logic of one led channel
// depends on lbk_pkg

module lbk_chan
  import lbk_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  chan_cmd_t            cmd,
  input  logic [PERIOD_W-1:0]  period,
  input  logic [TIME_BITS-1:0] now,
  output logic                 level,
  output logic                 armed
);

  localparam int SUM_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

  logic [PERIOD_W-1:0]  half_period;
  logic [TIME_BITS-1:0] deadline;
  logic [PERIOD_W-1:0]  half_period_next;
  logic [TIME_BITS-1:0] deadline_next;
  logic                 level_next;
  logic                 armed_next;
  logic [PERIOD_W-1:0]  add_period;
  logic [SUM_W-1:0]     sum;
  logic                 due;

  assign due = armed && (half_period != '0) && (now >= deadline);
  // tick reschedules with the stored period, blink with the new one
  assign add_period = cmd.tick ? half_period : period;
  assign sum = SUM_W'(now) + SUM_W'(add_period);

  always_comb begin
    half_period_next = half_period;
    deadline_next    = deadline;
    level_next       = level;
    armed_next       = armed;
    if (cmd.tick) begin
      if (due) begin
        level_next    = !level;
        deadline_next = sum[TIME_BITS-1:0];
      end
    end else if (cmd.set_on) begin
      armed_next = 1'b0;
      level_next = 1'b1;
    end else if (cmd.set_off) begin
      armed_next = 1'b0;
      level_next = 1'b0;
    end else if (cmd.blink) begin
      if (!armed) begin
        armed_next       = 1'b1;
        half_period_next = period;
        deadline_next    = sum[TIME_BITS-1:0];
      end
    end else if (cmd.stop) begin
      if (armed) begin
        armed_next = 1'b0;
        level_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
      armed <= 1'b0;
    end else if (en) begin
      level <= level_next;
      armed <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_period <= half_period_next;
      deadline    <= deadline_next;
    end
  end

endmodule

// ===== design/five_channel_led_blinker.sv =====
// five_channel_led_blinker: top level, input register, channel array, result register
// depends on lbk_pkg, lbk_in_stage, lbk_chan
//
// Usage: drives CHANNELS led levels, each steady or blinking.
// Input channel (in_valid/in_ready) carries action, channel, interval_ms and
// now_ms; one transfer per item. Actions: tick, steady on, steady off,
// start blink, stop blink. Undefined actions and out-of-range channels
// change nothing but still produce a result.
// Output channel (out_valid/out_ready) gives one transfer per item with
// led_levels and armed_mask for channels 0 to 4 after that item.
// Order: an accepted item is captured in the input register; when it
// advances, it updates all channels and lands in the result register, and
// out_valid rises with that load; the result transfer follows from there.
// Throughput: one item per cycle while results are taken; a tick evaluates every
// channel's deadline compare and reschedule add in parallel.
// Reset: all channels disarmed with leds off; both registers empty.
// Stall: while out_ready is low with a result held, the input register
// still takes one item, then in_ready drops until the result is taken.

module five_channel_led_blinker
  import lbk_pkg::*;
#(
  parameter int CHANNELS  = 5,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [PERIOD_W-1:0]  interval_ms,
  input  logic [NOW_W-1:0]     now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     led_levels,
  output logic [OUT_W-1:0]     armed_mask
);

  item_t                in_item;
  item_t                item;
  logic                 item_valid;
  logic                 advance;
  logic [TIME_BITS-1:0] now;
  logic                 is_cmd;
  logic [CHANNELS-1:0]  level;
  logic [CHANNELS-1:0]  armed;
  logic [OUT_W-1:0]     led_levels_next;
  logic [OUT_W-1:0]     armed_mask_next;

  assign in_item.action      = action;
  assign in_item.channel     = channel;
  assign in_item.interval_ms = interval_ms;
  assign in_item.now_ms      = now_ms;

  lbk_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  assign advance = item_valid && (!out_valid || out_ready);
  assign now     = TIME_BITS'(item.now_ms);
  assign is_cmd  = (item.action != ACT_TICK);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic      sel;
    chan_cmd_t cmd;

    assign sel         = is_cmd && ({{(32-CHANNEL_W){1'b0}}, item.channel} == 32'(i));
    assign cmd.tick    = (item.action == ACT_TICK);
    assign cmd.set_on  = sel && (item.action == ACT_ON);
    assign cmd.set_off = sel && (item.action == ACT_OFF);
    assign cmd.blink   = sel && (item.action == ACT_BLINK);
    assign cmd.stop    = sel && (item.action == ACT_STOP);

    lbk_chan #(
      .TIME_BITS (TIME_BITS)
    ) u_chan (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .cmd    (cmd),
      .period (item.interval_ms),
      .now    (now),
      .level  (level[i]),
      .armed  (armed[i])
    );
  end

  // result taken from the channel next values through a registered snapshot
  for (genvar i = 0; i < OUT_W; i++) begin : g_out
    if (i < CHANNELS) begin : g_used
      assign led_levels_next[i] = g_chan[i].u_chan.level_next;
      assign armed_mask_next[i] = g_chan[i].u_chan.armed_next;
    end else begin : g_unused
      assign led_levels_next[i] = 1'b0;
      assign armed_mask_next[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_levels <= led_levels_next;
      armed_mask <= armed_mask_next;
    end
  end

  // level and armed are unused; the outputs are taken from the channel next values
  logic unused_state;
  assign unused_state = ^{level, armed};

endmodule

// ===== tb/sv/five_channel_led_blinker_test.sv =====
// five_channel_led_blinker_test: self-checking testbench for the five-channel led blinker
// predicts led levels and armed mask per transfer, random idling on both sides
// depends on lbk_pkg and five_channel_led_blinker

module five_channel_led_blinker_test
  import lbk_pkg::*;
();

  localparam int CHAN_COUNT   = 5;
  localparam int IDLE_MAX     = 6;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [ACTION_W-1:0]  ACT_CODE_MAX  = '1;
  localparam logic [CHANNEL_W-1:0] CHAN_CODE_MAX = '1;

  typedef struct {
    logic [OUT_W-1:0] led_levels;
    logic [OUT_W-1:0] armed_mask;
  } blinker_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  action = '0;
  logic [CHANNEL_W-1:0] channel = '0;
  logic [PERIOD_W-1:0]  interval_ms = '0;
  logic [NOW_W-1:0]     now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     led_levels;
  logic [OUT_W-1:0]     armed_mask;

  // predicted channel state
  bit                ch_armed[CHAN_COUNT];
  bit [PERIOD_W-1:0] ch_half[CHAN_COUNT];
  bit [NOW_W-1:0]    ch_deadline[CHAN_COUNT];
  bit                ch_level[CHAN_COUNT];

  blinker_view_t pending_views[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            tx_gap_max = IDLE_MAX;
  int            rx_stall_max = IDLE_MAX;
  int            hold_request = 0;
  logic [NOW_W-1:0] clock_ms = '0;

  five_channel_led_blinker uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .channel     (channel),
    .interval_ms (interval_ms),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .led_levels  (led_levels),
    .armed_mask  (armed_mask)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void apply_led_command(input logic [ACTION_W-1:0] act,
                                            input logic [CHANNEL_W-1:0] chan,
                                            input logic [PERIOD_W-1:0] iv,
                                            input logic [NOW_W-1:0] ms);
    blinker_view_t view;
    int i;
    if (act == ACT_TICK) begin
      for (i = 0; i < CHAN_COUNT; i++) begin
        if (ch_armed[i] && ch_half[i] != 0 && ms >= ch_deadline[i]) begin
          ch_level[i] = !ch_level[i];
          ch_deadline[i] = ms + {1'b0, ch_half[i]};
        end
      end
    end else if (chan < CHAN_COUNT) begin
      case (act)
        ACT_ON: begin
          ch_armed[chan] = 1'b0;
          ch_level[chan] = 1'b1;
        end
        ACT_OFF: begin
          ch_armed[chan] = 1'b0;
          ch_level[chan] = 1'b0;
        end
        ACT_BLINK: begin
          if (!ch_armed[chan]) begin
            ch_armed[chan] = 1'b1;
            ch_half[chan] = iv;
            ch_deadline[chan] = ms + {1'b0, iv};
          end
        end
        ACT_STOP: begin
          if (ch_armed[chan]) begin
            ch_armed[chan] = 1'b0;
            ch_level[chan] = 1'b0;
          end
        end
        default: ;
      endcase
    end
    view.led_levels = '0;
    view.armed_mask = '0;
    for (i = 0; i < CHAN_COUNT; i++) begin
      view.led_levels[i] = ch_level[i];
      view.armed_mask[i] = ch_armed[i];
    end
    pending_views.push_back(view);
  endfunction

  task automatic send_led_command(input logic [ACTION_W-1:0] act,
                                  input logic [CHANNEL_W-1:0] chan,
                                  input logic [PERIOD_W-1:0] iv,
                                  input logic [NOW_W-1:0] ms);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    channel     <= chan;
    interval_ms <= iv;
    now_ms      <= ms;
    do @(posedge clk); while (!in_ready);
    apply_led_command(act, chan, iv, ms);
  endtask

  function automatic void compare_led_result();
    blinker_view_t want;
    if (pending_views.size() == 0) begin
      $error("result transfer with no expected result: led_levels %0h armed_mask %0h",
             led_levels, armed_mask);
      mismatch_count++;
    end else begin
      want = pending_views.pop_front();
      if (led_levels !== want.led_levels) begin
        $error("led_levels: expected %0h, actual %0h", want.led_levels, led_levels);
        mismatch_count++;
      end
      if (armed_mask !== want.armed_mask) begin
        $error("armed_mask: expected %0h, actual %0h", want.armed_mask, armed_mask);
        mismatch_count++;
      end
    end
  endfunction

  // result receiver with random stalls and a single long hold-off
  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      compare_led_result();
    end
  end

  task automatic test_idle_and_noise();
    send_led_command(ACT_TICK, '0, '0, '0);
    send_led_command(ACT_STOP + 3'd1, 3'd0, 31'd5, 32'd0);
    send_led_command(ACT_STOP + 3'd2, 3'd1, '1, '1);
    send_led_command(ACT_CODE_MAX, 3'd2, 31'd7, 32'd3);
    send_led_command(ACT_ON, CHANNEL_W'(CHAN_COUNT), '0, '0);
    send_led_command(ACT_BLINK, CHAN_CODE_MAX, 31'd1, 32'd0);
  endtask

  task automatic test_steady_levels();
    int i;
    for (i = 0; i < CHAN_COUNT; i++) send_led_command(ACT_ON, CHANNEL_W'(i), '0, '0);
    send_led_command(ACT_OFF, 3'd0, '0, '0);
    send_led_command(ACT_OFF, 3'd4, '1, '1);
  endtask

  task automatic test_blink_cases();
    // zero half period arms but never toggles
    send_led_command(ACT_BLINK, 3'd1, 31'd0, 32'd100);
    send_led_command(ACT_BLINK, 3'd2, 31'd10, 32'd100);
    // second blink on an armed channel is ignored
    send_led_command(ACT_BLINK, 3'd2, 31'd3, 32'd101);
    send_led_command(ACT_TICK, '0, '0, 32'd109);
    send_led_command(ACT_TICK, '0, '0, 32'd110);
    // stop on an idle channel is ignored
    send_led_command(ACT_STOP, 3'd3, '0, '0);
    send_led_command(ACT_ON, 3'd1, '0, '0);
    send_led_command(ACT_STOP, 3'd2, '0, '0);
    // deadline wraps past the top of the time range
    send_led_command(ACT_BLINK, 3'd0, '1, '1);
    send_led_command(ACT_TICK, '0, '0, '1);
  endtask

  task automatic test_output_backpressure();
    int i;
    tx_gap_max = 0;
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 12; i++) begin
      send_led_command(ACT_TICK, '0, '0, clock_ms);
      clock_ms = clock_ms + 32'd3;
    end
    tx_gap_max = IDLE_MAX;
  endtask

  task automatic test_random_sequences();
    int n;
    int pick;
    bit quiet;
    logic [ACTION_W-1:0]  act;
    logic [CHANNEL_W-1:0] chan;
    logic [PERIOD_W-1:0]  iv;
    logic [NOW_W-1:0]     ms;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
        tx_gap_max = quiet ? 0 : IDLE_MAX;
        rx_stall_max = quiet ? 0 : IDLE_MAX;
      end
      if ($urandom_range(0, 149) == 0) clock_ms = '1 - NOW_W'($urandom_range(0, 60));
      clock_ms = clock_ms + NOW_W'($urandom_range(0, 6));
      chan = CHANNEL_W'($urandom_range(0, CHAN_COUNT - 1));
      iv = PERIOD_W'($urandom_range(1, 20));
      ms = clock_ms;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        act = ACTION_W'($urandom_range(0, ACT_CODE_MAX));
        chan = CHANNEL_W'($urandom_range(0, CHAN_CODE_MAX));
        iv = PERIOD_W'($urandom);
        ms = $urandom;
      end else if (pick < 45) begin
        act = ACT_TICK;
      end else if (pick < 65) begin
        act = ACT_BLINK;
        case ($urandom_range(0, 9))
          0: iv = '0;
          1, 2: iv = PERIOD_W'($urandom);
          default: ;
        endcase
      end else if (pick < 80) begin
        act = $urandom_range(0, 1) ? ACT_ON : ACT_OFF;
      end else if (pick < 95) begin
        act = ACT_STOP;
      end else begin
        act = $urandom_range(0, 1) ? ACT_BLINK : ACT_ON;
        chan = CHANNEL_W'($urandom_range(CHAN_COUNT, CHAN_CODE_MAX));
      end
      send_led_command(act, chan, iv, ms);
    end
    tx_gap_max = IDLE_MAX;
    rx_stall_max = IDLE_MAX;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_noise();
    test_steady_levels();
    test_blink_cases();
    test_output_backpressure();
    test_random_sequences();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lbk_pkg.sv
design/lbk_in_stage.sv
design/lbk_chan.sv
design/five_channel_led_blinker.sv
tb/sv/five_channel_led_blinker_test.sv
